@@ rtl/pll_pkg.sv @@
// Package for the pooled linked list engine: request/result structs,
// opcode and status codes. No dependencies.
package pll_pkg;
  localparam int unsigned IdxW = 7;
  localparam logic [IdxW-1:0] Nil = 7'd127;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_INS_AFTER  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_DEL_AFTER  = 3'd5,
    OP_READ_OUT   = 3'd6,
    OP_NOP        = 3'd7
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NO_NEXT   = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] search_key;
    logic signed [31:0] new_value;
  } request_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] item_value;
    logic               has_item;
    logic               last;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic            load_req;
    logic            scan_free;   // step free-slot scan
    logic            walk_reset;  // cur <= head, prev <= Nil, cnt <= 0
    logic            walk_step;   // prev <= cur, cur <= link[cur]
    logic            mem_read;    // fetch value/link of cur
    logic            wr_node;     // write new node at free slot
    logic [IdxW-1:0] wr_link;
    logic            set_link;    // link[link_addr] <= link_data
    logic [IdxW-1:0] link_addr;
    logic [IdxW-1:0] link_data;
    logic            set_head;
    logic [IdxW-1:0] head_data;
    logic            free_slot;
    logic [IdxW-1:0] free_addr;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0]      opcode;
    logic            empty;
    logic            free_done;
    logic            free_found;
    logic [IdxW-1:0] free_idx;
    logic [IdxW-1:0] head;
    logic [IdxW-1:0] cur;
    logic [IdxW-1:0] prev;
    logic            cur_live;
    logic [IdxW-1:0] cur_link;
    logic            link_live;
    logic            key_hit;
    logic            cnt_end;    // walk count reached depth-1
    logic signed [31:0] cur_value;
  } dp_stat_t;
endpackage

@@ rtl/pll_datapath.sv @@
// Datapath: node memories, used bits, head, walk and free-scan registers.
// Depends on pll_pkg.
module pll_datapath #(
  parameter int unsigned POOL_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  pll_pkg::request_t req_in,
  input  pll_pkg::dp_cmd_t  cmd,
  output pll_pkg::dp_stat_t stat
);
  import pll_pkg::*;
  localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

  logic signed [31:0] node_value [POOL_DEPTH];
  logic [IdxW-1:0]    node_link  [POOL_DEPTH];
  logic [POOL_DEPTH-1:0] slot_used;
  logic [IdxW-1:0] head_index;
  request_t        req;
  logic [IdxW-1:0] cur, prev, scan, free_idx, cnt;
  logic            free_found, free_done;
  logic signed [31:0] rd_value;
  logic [IdxW-1:0]    rd_link;

  function automatic logic is_live(logic [IdxW-1:0] i, logic [POOL_DEPTH-1:0] u);
    logic r;
    r = 1'b0;
    if (i < IdxW'(POOL_DEPTH)) r = u[i[AW-1:0]];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load_req) req <= req_in;
    if (cmd.mem_read) begin
      rd_value <= node_value[cur[AW-1:0]];
      rd_link  <= node_link[cur[AW-1:0]];
    end
    if (cmd.wr_node) begin
      node_value[free_idx[AW-1:0]] <= req.new_value;
      node_link[free_idx[AW-1:0]]  <= cmd.wr_link;
    end else if (cmd.set_link) begin
      node_link[cmd.link_addr[AW-1:0]] <= cmd.link_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used  <= '0;
      head_index <= Nil;
      cur        <= Nil;
      prev       <= Nil;
      cnt        <= '0;
      scan       <= '0;
      free_idx   <= Nil;
      free_found <= 1'b0;
      free_done  <= 1'b0;
    end else begin
      if (cmd.load_req) begin
        scan <= '0; free_found <= 1'b0; free_done <= 1'b0; free_idx <= Nil;
      end else if (cmd.scan_free && !free_done) begin
        if (!slot_used[scan[AW-1:0]]) begin
          free_found <= 1'b1; free_done <= 1'b1; free_idx <= scan;
        end else if (scan == IdxW'(POOL_DEPTH - 1)) begin
          free_done <= 1'b1;
        end
        scan <= scan + IdxW'(1);
      end
      if (cmd.walk_reset) begin
        cur <= head_index; prev <= Nil; cnt <= '0;
      end else if (cmd.walk_step) begin
        prev <= cur; cur <= rd_link; cnt <= cnt + IdxW'(1);
      end
      if (cmd.set_head) head_index <= cmd.head_data;
      if (cmd.wr_node) slot_used[free_idx[AW-1:0]] <= 1'b1;
      if (cmd.free_slot) slot_used[cmd.free_addr[AW-1:0]] <= 1'b0;
    end
  end

  always_comb begin
    stat.opcode     = req.opcode;
    stat.empty      = !is_live(head_index, slot_used);
    stat.free_done  = free_done;
    stat.free_found = free_found;
    stat.free_idx   = free_idx;
    stat.head       = head_index;
    stat.cur        = cur;
    stat.prev       = prev;
    stat.cur_live   = is_live(cur, slot_used);
    stat.cur_link   = rd_link;
    stat.link_live  = is_live(rd_link, slot_used);
    stat.key_hit    = (rd_value == req.search_key);
    stat.cnt_end    = (cnt == IdxW'(POOL_DEPTH - 1));
    stat.cur_value  = rd_value;
  end
endmodule

@@ rtl/pll_controller.sv @@
// Controller state machine: sequences walks and updates per opcode.
// Depends on pll_pkg.
module pll_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output pll_pkg::dp_cmd_t  cmd,
  input  pll_pkg::dp_stat_t stat,
  output logic              strobe,
  output pll_pkg::result_t  result
);
  import pll_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_FREE, S_KEY_RD, S_KEY_CHK,
    S_TAIL_RD, S_TAIL_CHK, S_DEL_RD, S_APPLY, S_LINK, S_OUT_RD, S_OUT_EMIT
  } state_t;

  state_t state;
  logic [IdxW-1:0] keynode, tail, tail_prev, del_node;

  function automatic result_t mk(status_t s, logic signed [31:0] v, logic h, logic l);
    result_t r;
    r.status = s; r.item_value = v; r.has_item = h; r.last = l;
    return r;
  endfunction

  always_comb begin
    cmd = '0;
    cmd.load_req = start && !busy;
    unique case (state)
      S_DISPATCH: begin
        cmd.walk_reset = 1'b1;
      end
      S_FREE: cmd.scan_free = 1'b1;
      S_KEY_RD, S_TAIL_RD, S_OUT_RD: cmd.mem_read = 1'b1;
      S_DEL_RD: cmd.mem_read = 1'b1;
      // delete-after moves onto the node to drop once the key is hit
      S_KEY_CHK: if (stat.link_live &&
                     (stat.key_hit ? (stat.opcode == OP_DEL_AFTER) : !stat.cnt_end))
                   cmd.walk_step = 1'b1;
      S_TAIL_CHK: if (stat.link_live && !stat.cnt_end) cmd.walk_step = 1'b1;
      S_OUT_EMIT: if (stat.link_live && !stat.cnt_end) cmd.walk_step = 1'b1;
      S_LINK: begin
        cmd.set_link  = 1'b1;
        cmd.link_addr = (stat.opcode == OP_INS_AFTER) ? keynode : tail;
        cmd.link_data = stat.free_idx;
      end
      default: ;
    endcase
    if (state == S_APPLY) begin
      case (stat.opcode)
        OP_PUSH_FRONT: if (stat.free_found) begin
          cmd.wr_node = 1'b1; cmd.wr_link = stat.empty ? Nil : stat.head;
          cmd.set_head = 1'b1; cmd.head_data = stat.free_idx;
        end
        OP_PUSH_BACK: if (stat.free_found) begin
          cmd.wr_node = 1'b1; cmd.wr_link = Nil;
          if (stat.empty) begin
            cmd.set_head = 1'b1; cmd.head_data = stat.free_idx;
          end
        end
        OP_INS_AFTER: if (stat.free_found) begin
          cmd.wr_node = 1'b1; cmd.wr_link = stat.link_live ? stat.cur_link : Nil;
        end
        OP_POP_FRONT: if (!stat.empty) begin
          cmd.set_head = 1'b1; cmd.head_data = stat.link_live ? stat.cur_link : Nil;
          cmd.free_slot = 1'b1; cmd.free_addr = stat.head;
        end
        OP_POP_BACK: if (!stat.empty) begin
          if (tail_prev == Nil) begin
            cmd.set_head = 1'b1; cmd.head_data = Nil;
          end else begin
            cmd.set_link = 1'b1; cmd.link_addr = tail_prev; cmd.link_data = Nil;
          end
          cmd.free_slot = 1'b1; cmd.free_addr = tail;
        end
        OP_DEL_AFTER: begin
          cmd.set_link = 1'b1; cmd.link_addr = keynode;
          cmd.link_data = stat.link_live ? stat.cur_link : Nil;
          cmd.free_slot = 1'b1; cmd.free_addr = del_node;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; busy <= 1'b0; strobe <= 1'b0; result <= '0;
      keynode <= Nil; tail <= Nil; tail_prev <= Nil; del_node <= Nil;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          state <= S_DISPATCH; busy <= 1'b1;
        end
        S_DISPATCH: begin
          unique case (stat.opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK: state <= S_FREE;
            OP_INS_AFTER: state <= stat.empty ? S_IDLE : S_KEY_RD;
            OP_POP_FRONT: state <= stat.empty ? S_IDLE : S_DEL_RD;
            OP_POP_BACK, OP_DEL_AFTER:
              state <= stat.empty ? S_IDLE : (stat.opcode == OP_POP_BACK ? S_TAIL_RD
                                                                          : S_KEY_RD);
            OP_READ_OUT: state <= stat.empty ? S_IDLE : S_OUT_RD;
            default: begin state <= S_IDLE; busy <= 1'b0; end
          endcase
          if (stat.empty && stat.opcode != OP_NOP && stat.opcode != OP_PUSH_FRONT &&
              stat.opcode != OP_PUSH_BACK) begin
            strobe <= 1'b1; busy <= 1'b0;
            result <= mk(stat.opcode == OP_INS_AFTER ? ST_NOT_FOUND : ST_EMPTY,
                         32'sd0, 1'b0, 1'b1);
          end
        end
        S_FREE: if (stat.free_done) begin
          if (!stat.free_found) begin
            state <= S_IDLE; busy <= 1'b0; strobe <= 1'b1;
            result <= mk(ST_FULL, 32'sd0, 1'b0, 1'b1);
          end else if (stat.opcode == OP_PUSH_BACK && !stat.empty) begin
            state <= S_TAIL_RD;
          end else if (stat.opcode == OP_INS_AFTER) begin
            state <= S_DEL_RD;   // refetch key node's link
          end else begin
            state <= S_APPLY;
          end
        end
        S_KEY_RD: state <= S_KEY_CHK;
        S_KEY_CHK: begin
          if (stat.key_hit) begin
            keynode <= stat.cur;
            if (stat.opcode == OP_INS_AFTER) state <= S_FREE;
            else if (!stat.link_live) begin
              state <= S_IDLE; busy <= 1'b0; strobe <= 1'b1;
              result <= mk(ST_NO_NEXT, 32'sd0, 1'b0, 1'b1);
            end else begin
              del_node <= stat.cur_link;
              state <= S_DEL_RD;
            end
          end else if (stat.link_live && !stat.cnt_end) begin
            state <= S_KEY_RD;
          end else begin
            state <= S_IDLE; busy <= 1'b0; strobe <= 1'b1;
            result <= mk(ST_NOT_FOUND, 32'sd0, 1'b0, 1'b1);
          end
        end
        S_TAIL_RD: state <= S_TAIL_CHK;
        S_TAIL_CHK: if (!(stat.link_live && !stat.cnt_end)) begin
          tail <= stat.cur; tail_prev <= stat.prev; state <= S_APPLY;
        end else state <= S_TAIL_RD;
        S_DEL_RD: state <= S_APPLY;
        S_APPLY: begin
          if ((stat.opcode == OP_PUSH_BACK && !stat.empty) || stat.opcode == OP_INS_AFTER) begin
            state <= S_LINK;
          end else begin
            state <= S_IDLE; busy <= 1'b0; strobe <= 1'b1;
            result <= mk(ST_OK, 32'sd0, 1'b0, 1'b1);
          end
        end
        S_LINK: begin
          state <= S_IDLE; busy <= 1'b0; strobe <= 1'b1;
          result <= mk(ST_OK, 32'sd0, 1'b0, 1'b1);
        end
        S_OUT_RD: state <= S_OUT_EMIT;
        S_OUT_EMIT: begin
          strobe <= 1'b1;
          if (stat.link_live && !stat.cnt_end) begin
            result <= mk(ST_OK, stat.cur_value, 1'b1, 1'b0);
            state <= S_OUT_RD;
          end else begin
            result <= mk(ST_OK, stat.cur_value, 1'b1, 1'b1);
            state <= S_IDLE; busy <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/pooled_linked_list_engine.sv @@
// Top level of the pooled linked list engine.
// Depends on pll_pkg, pll_controller, pll_datapath.
//
//  port    dir  handshake            payload
//  request in   start & !busy        request_t (opcode, search_key, new_value)
//  result  out  strobe, one cycle    result_t (status, item_value, has_item, last)
//
// One request at a time. Pop front is the shortest list update; push back
// and insert after are the longest (free-slot scan one slot per cycle plus
// a walk that visits each node in a read state and then a check state).
// Read-out gives one result per node, from a read state and an emit state in
// turn. Synchronous reset clears used bits and head; no clearing pass.
// The receiver cannot stall; busy drops with the last result.
module pooled_linked_list_engine #(
  parameter int unsigned POOL_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pll_pkg::request_t request,
  output logic              strobe,
  output pll_pkg::result_t  result
);
  import pll_pkg::*;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  pll_controller u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .stat(stat), .strobe(strobe), .result(result)
  );

  pll_datapath #(.POOL_DEPTH(POOL_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .req_in(request), .cmd(cmd), .stat(stat)
  );
endmodule

@@ dv/tb_top.sv @@
// Testbench for pooled_linked_list_engine: random and directed list requests,
// results checked against a behavioral list model. Depends on pll_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;
  import pll_pkg::*;

  localparam int Depth = 64;
  localparam int StallLimit = 20000;

  class list_scoreboard;
    logic [31:0] val [Depth];
    logic [6:0]  link [Depth];
    bit          used [Depth];
    logic [6:0]  head;
    result_t     pending [$];
    int          errors;

    function new();
      head = Nil;
      errors = 0;
      foreach (used[i]) used[i] = 0;
    endfunction

    function bit live(logic [6:0] i);
      return i < Depth && used[i];
    endfunction

    function logic [6:0] lowest_free();
      for (int i = 0; i < Depth; i++) if (!used[i]) return 7'(i);
      return Nil;
    endfunction

    function logic [6:0] find_key(logic [31:0] key);
      logic [6:0] cur;
      cur = head;
      for (int n = 0; n < Depth && live(cur); n++) begin
        if (val[cur] == key) return cur;
        cur = link[cur];
      end
      return Nil;
    endfunction

    function logic [6:0] find_tail(output logic [6:0] prev);
      logic [6:0] cur;
      cur = head;
      prev = Nil;
      for (int n = 1; n < Depth && live(link[cur]); n++) begin
        prev = cur;
        cur = link[cur];
      end
      return cur;
    endfunction

    function void take(logic [6:0] s, logic [31:0] v, logic [6:0] l);
      val[s] = v;
      link[s] = l;
      used[s] = 1;
    endfunction

    function void push_status(status_t st);
      result_t r;
      r = '{status: st, item_value: 0, has_item: 0, last: 1};
      pending.push_back(r);
    endfunction

    function void note_request(request_t rq);
      logic [6:0] s, k, d, prev, tail, cur;
      bit empty, more;
      result_t r;
      empty = !live(head);
      case (opcode_t'(rq.opcode))
        OP_PUSH_FRONT: begin
          s = lowest_free();
          if (s == Nil) push_status(ST_FULL);
          else begin
            take(s, rq.new_value, empty ? Nil : head);
            head = s;
            push_status(ST_OK);
          end
        end
        OP_PUSH_BACK: begin
          s = lowest_free();
          if (s == Nil) push_status(ST_FULL);
          else begin
            if (empty) begin
              take(s, rq.new_value, Nil);
              head = s;
            end else begin
              tail = find_tail(prev);
              take(s, rq.new_value, Nil);
              link[tail] = s;
            end
            push_status(ST_OK);
          end
        end
        OP_INS_AFTER: begin
          k = find_key(rq.search_key);
          s = lowest_free();
          if (k == Nil) push_status(ST_NOT_FOUND);
          else if (s == Nil) push_status(ST_FULL);
          else begin
            take(s, rq.new_value, live(link[k]) ? link[k] : Nil);
            link[k] = s;
            push_status(ST_OK);
          end
        end
        OP_POP_FRONT: begin
          if (empty) push_status(ST_EMPTY);
          else begin
            s = head;
            head = live(link[s]) ? link[s] : Nil;
            used[s] = 0;
            push_status(ST_OK);
          end
        end
        OP_POP_BACK: begin
          if (empty) push_status(ST_EMPTY);
          else begin
            tail = find_tail(prev);
            if (prev == Nil) head = Nil;
            else link[prev] = Nil;
            used[tail] = 0;
            push_status(ST_OK);
          end
        end
        OP_DEL_AFTER: begin
          if (empty) push_status(ST_EMPTY);
          else begin
            k = find_key(rq.search_key);
            if (k == Nil) push_status(ST_NOT_FOUND);
            else begin
              d = link[k];
              if (!live(d)) push_status(ST_NO_NEXT);
              else begin
                link[k] = live(link[d]) ? link[d] : Nil;
                used[d] = 0;
                push_status(ST_OK);
              end
            end
          end
        end
        OP_READ_OUT: begin
          if (empty) push_status(ST_EMPTY);
          else begin
            cur = head;
            for (int n = 0; n < Depth; n++) begin
              more = (n + 1 < Depth) && live(link[cur]);
              r = '{status: ST_OK, item_value: val[cur], has_item: 1, last: !more};
              pending.push_back(r);
              if (!more) break;
              cur = link[cur];
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status)
        $display("%0t status exp %0d got %0d", $time, exp.status, got.status);
      if (got.item_value !== exp.item_value)
        $display("%0t item_value exp %h got %h", $time, exp.item_value, got.item_value);
      if (got.has_item !== exp.has_item)
        $display("%0t has_item exp %b got %b", $time, exp.has_item, got.has_item);
      if (got.last !== exp.last)
        $display("%0t last exp %b got %b", $time, exp.last, got.last);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic     clk = 0;
  logic     rst = 1;
  logic     start = 0;
  logic     busy;
  logic     strobe;
  request_t request = '0;
  result_t  result;
  list_scoreboard sb;
  int       idle_cycles = 0;
  bit       allow_gaps = 1;
  logic [31:0] keys [$];

  pooled_linked_list_engine dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .strobe(strobe), .result(result)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) sb.check_result(result);
      if ((start && !busy) || strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // called at a falling edge; leaves start high after the accepting edge
  task automatic issue(opcode_t op, logic [31:0] key, logic [31:0] v);
    request_t rq;
    rq.opcode = op;
    rq.search_key = key;
    rq.new_value = v;
    if (allow_gaps && $urandom_range(0, 2) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    request <= rq;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(rq);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    if (keys.size() > 0 && $urandom_range(0, 3) != 0)
      return keys[$urandom_range(0, keys.size() - 1)];
    return $urandom;
  endfunction

  initial begin
    logic [31:0] v;
    int op;
    sb = new();
    repeat (9) @(negedge clk);
    rst <= 0;
    // empty-list cases, then a few directed pushes, inserts, deletes and a read-out
    issue(OP_READ_OUT, 0, 0);
    issue(OP_POP_FRONT, 0, 0);
    issue(OP_POP_BACK, 0, 0);
    issue(OP_DEL_AFTER, 5, 0);
    issue(OP_INS_AFTER, 5, 1);
    issue(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(OP_PUSH_FRONT, 0, 32'h8000_0000);
    issue(OP_PUSH_BACK, 0, 32'h7FFF_FFFF);
    issue(OP_INS_AFTER, 32'h8000_0000, 32'hFFFF_FFFF);
    issue(OP_INS_AFTER, 32'h1234, 3);
    issue(OP_DEL_AFTER, 32'h7FFF_FFFF, 0);
    issue(OP_DEL_AFTER, 32'h1234, 0);
    issue(OP_DEL_AFTER, 32'h8000_0000, 0);
    issue(OP_READ_OUT, 0, 0);
    // fill the pool to full, push onto the full pool, read the full list, then take some nodes off and read again
    for (int i = 0; i < Depth; i++) issue(OP_PUSH_BACK, 0, i);
    issue(OP_PUSH_FRONT, 0, 1);
    issue(OP_INS_AFTER, 3, 1);
    issue(OP_READ_OUT, 0, 0);
    for (int i = 0; i < 4; i++) issue(OP_POP_BACK, 0, 0);
    for (int i = 0; i < 4; i++) issue(OP_POP_FRONT, 0, 0);
    issue(OP_READ_OUT, 0, 0);
    // random part
    for (int i = 0; i < 20; i++) begin
      if (i > 15) allow_gaps = 0;
      op = $urandom_range(0, 20);
      v = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 15);
      if (op < 5) begin
        keys.push_back(v);
        issue(OP_PUSH_FRONT, 0, v);
      end else if (op < 9) begin
        keys.push_back(v);
        issue(OP_PUSH_BACK, 0, v);
      end else if (op < 12) begin
        keys.push_back(v);
        issue(OP_INS_AFTER, pick_key(), v);
      end else if (op < 13) issue(OP_POP_FRONT, $urandom, $urandom);
      else if (op < 14) issue(OP_POP_BACK, $urandom, $urandom);
      else if (op < 17) issue(OP_DEL_AFTER, pick_key(), $urandom);
      else if (op < 20) issue(OP_READ_OUT, $urandom, $urandom);
      else issue(OP_NOP, $urandom, $urandom);
    end
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2 * Depth + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
